### sv/assert_macros.svh
// assertion helpers included by utgr_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold every cycle out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/utgr_pkg.sv
// ----------------------------------------------------------------------------
// utgr_pkg
// types, constants and glyph lookup for the text glyph rasterizer
// ----------------------------------------------------------------------------
package utgr_pkg;

  localparam int ROM_ROWS = 7;
  localparam int ROM_COLS = 5;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  typedef logic [ROM_COLS-1:0] glyph_row_t;
  typedef glyph_row_t [ROM_ROWS-1:0] glyph_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item and decode
    logic second;     // start second (cut-short) character
    logic step;       // advance scan position
    logic advance;    // cursor advance after a character
    logic clear;      // end of string
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic two_chars;  // item yields two characters
    logic draw1;      // first character drawn
    logic dot;        // current scan position is a set dot
    logic scan_end;   // current scan position is the last one
    logic more_dots;  // a set dot follows the current position in this character
    logic more_second;// second character has any dot
  } dp_stat_t;

  function automatic logic [15:0] fold_alias(input logic [15:0] c);
    logic [15:0] f;
    f = c;
    if (c >= 16'h0061 && c <= 16'h007A) f = c - 16'd32;
    else if (c >= 16'h0430 && c <= 16'h044F) f = c - 16'd32;
    else if (c == 16'h0451) f = 16'h0401;
    case (f)
      16'h0410: f = 16'h0041;
      16'h0412: f = 16'h0042;
      16'h0415, 16'h0401: f = 16'h0045;
      16'h041A: f = 16'h004B;
      16'h041C: f = 16'h004D;
      16'h041D: f = 16'h0048;
      16'h041E: f = 16'h004F;
      16'h0420: f = 16'h0050;
      16'h0421: f = 16'h0043;
      16'h0422: f = 16'h0054;
      16'h0423: f = 16'h0059;
      16'h0425: f = 16'h0058;
      default: f = f;
    endcase
    return f;
  endfunction

  function automatic glyph_t g(input int r0, r1, r2, r3, r4, r5, r6);
    glyph_t v;
    v[0] = glyph_row_t'(r0); v[1] = glyph_row_t'(r1); v[2] = glyph_row_t'(r2);
    v[3] = glyph_row_t'(r3); v[4] = glyph_row_t'(r4); v[5] = glyph_row_t'(r5);
    v[6] = glyph_row_t'(r6);
    return v;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [15:0] code);
    glyph_t v;
    v = '0;
    case (fold_alias(code))
      16'h0041: v = g(14, 17, 17, 31, 17, 17, 17);
      16'h0042: v = g(30, 17, 17, 30, 17, 17, 30);
      16'h0043: v = g(14, 17, 16, 16, 16, 17, 14);
      16'h0044: v = g(30, 17, 17, 17, 17, 17, 30);
      16'h0045: v = g(31, 16, 16, 30, 16, 16, 31);
      16'h0046: v = g(31, 16, 16, 30, 16, 16, 16);
      16'h0047: v = g(14, 17, 16, 23, 17, 17, 14);
      16'h0048: v = g(17, 17, 17, 31, 17, 17, 17);
      16'h0049: v = g(31, 4, 4, 4, 4, 4, 31);
      16'h004A: v = g(7, 2, 2, 2, 18, 18, 12);
      16'h004B: v = g(17, 18, 20, 24, 20, 18, 17);
      16'h004C: v = g(16, 16, 16, 16, 16, 16, 31);
      16'h004D: v = g(17, 27, 21, 21, 17, 17, 17);
      16'h004E: v = g(17, 25, 21, 19, 17, 17, 17);
      16'h004F: v = g(14, 17, 17, 17, 17, 17, 14);
      16'h0050: v = g(30, 17, 17, 30, 16, 16, 16);
      16'h0051: v = g(14, 17, 17, 17, 21, 18, 13);
      16'h0052: v = g(30, 17, 17, 30, 20, 18, 17);
      16'h0053: v = g(15, 16, 16, 14, 1, 1, 30);
      16'h0054: v = g(31, 4, 4, 4, 4, 4, 4);
      16'h0055: v = g(17, 17, 17, 17, 17, 17, 14);
      16'h0056: v = g(17, 17, 17, 17, 17, 10, 4);
      16'h0057: v = g(17, 17, 17, 21, 21, 21, 10);
      16'h0058: v = g(17, 17, 10, 4, 10, 17, 17);
      16'h0059: v = g(17, 17, 10, 4, 4, 4, 4);
      16'h005A: v = g(31, 1, 2, 4, 8, 16, 31);
      16'h0030: v = g(14, 17, 19, 21, 25, 17, 14);
      16'h0031: v = g(4, 12, 4, 4, 4, 4, 14);
      16'h0032: v = g(14, 17, 1, 2, 4, 8, 31);
      16'h0033: v = g(30, 1, 1, 14, 1, 1, 30);
      16'h0034: v = g(2, 6, 10, 18, 31, 2, 2);
      16'h0035: v = g(31, 16, 16, 30, 1, 1, 30);
      16'h0036: v = g(14, 16, 16, 30, 17, 17, 14);
      16'h0037: v = g(31, 1, 2, 4, 8, 8, 8);
      16'h0038: v = g(14, 17, 17, 14, 17, 17, 14);
      16'h0039: v = g(14, 17, 17, 15, 1, 1, 14);
      16'h003A: v = g(0, 4, 4, 0, 4, 4, 0);
      16'h002F: v = g(1, 2, 2, 4, 8, 8, 16);
      16'h002D: v = g(0, 0, 0, 31, 0, 0, 0);
      16'h0411: v = g(31, 16, 16, 30, 17, 17, 30);
      16'h0413: v = g(31, 16, 16, 16, 16, 16, 16);
      16'h0414: v = g(6, 10, 10, 10, 10, 31, 17);
      16'h0416: v = g(21, 21, 14, 4, 14, 21, 21);
      16'h0417: v = g(30, 1, 1, 14, 1, 1, 30);
      16'h0418: v = g(17, 19, 21, 21, 21, 25, 17);
      16'h0419: v = g(10, 4, 17, 19, 21, 25, 17);
      16'h041B: v = g(7, 9, 9, 9, 9, 9, 17);
      16'h041F: v = g(31, 17, 17, 17, 17, 17, 17);
      16'h0424: v = g(4, 14, 21, 21, 14, 4, 4);
      16'h0426: v = g(17, 17, 17, 17, 17, 31, 1);
      16'h0427: v = g(17, 17, 17, 15, 1, 1, 1);
      16'h0428: v = g(21, 21, 21, 21, 21, 21, 31);
      16'h0429: v = g(21, 21, 21, 21, 21, 31, 1);
      16'h042A: v = g(24, 8, 8, 14, 9, 9, 14);
      16'h042B: v = g(17, 17, 17, 29, 19, 19, 29);
      16'h042C: v = g(16, 16, 16, 30, 17, 17, 30);
      16'h042D: v = g(14, 17, 1, 7, 1, 17, 14);
      16'h042E: v = g(17, 21, 21, 29, 21, 21, 17);
      16'h042F: v = g(15, 17, 17, 15, 5, 9, 17);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/utgr_datapath.sv
// ----------------------------------------------------------------------------
// utgr_datapath
// utf-8 decode state, glyph registers, dot scan counters and square coordinates
// ----------------------------------------------------------------------------
module utgr_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  utgr_pkg::dp_cmd_t  cmd,
  output utgr_pkg::dp_stat_t stat,
  input  logic [7:0]        in_text_byte,
  input  logic              in_last_byte,
  input  logic [15:0]       in_origin_x,
  input  logic [15:0]       in_origin_y,
  input  logic [7:0]        in_dot_scale,
  input  logic [7:0]        in_color_tag,
  output logic [15:0]       sq_x,
  output logic [15:0]       sq_y,
  output logic [7:0]        sq_size,
  output logic [7:0]        sq_color
);
  import utgr_pkg::*;

  logic [7:0]  lead_r, second_r;
  logic [1:0]  need_r;
  logic [15:0] cursor_r, cursor_nxt;
  logic [15:0] ox_r, oy_r;
  logic [7:0]  sc_r, col_r;
  logic        two_r, draw1_r;
  glyph_t      glyph_r, glyph2_r;
  logic [2:0]  row_r, col_idx_r;
  logic [16:0] xoff_r, yoff_r;

  logic [15:0] code1, code2;
  logic        draw1, two;
  logic [1:0]  need_nxt;
  logic [7:0]  lead_nxt, second_nxt;
  logic [7:0]  fb;
  logic        dot, scan_end, more;
  logic [5:0]  pos;
  logic [34:0] flat;
  logic [17:0] sx, sy;
  logic [17:0] cadd;

  // decode of the incoming byte
  always_comb begin
    code1 = 16'(CHAR_QMARK);
    code2 = 16'(CHAR_QMARK);
    draw1 = 1'b0;
    two = 1'b0;
    need_nxt = need_r;
    lead_nxt = lead_r;
    second_nxt = second_r;
    fb = in_text_byte;
    case (need_r)
      2'd2: begin
        if (in_last_byte) begin
          draw1 = 1'b1;
          two = 1'b1;
          need_nxt = 2'd0;
          code2 = (fb < 8'h80) ? 16'(fb) : 16'(CHAR_QMARK);
        end else begin
          second_nxt = fb;
          need_nxt = 2'd1;
        end
      end
      2'd1: begin
        draw1 = 1'b1;
        need_nxt = 2'd0;
        if ((lead_r & 8'hF0) == 8'hE0)
          code1 = {lead_r[3:0], second_r[5:0], fb[5:0]};
        else
          code1 = {5'd0, lead_r[4:0], fb[5:0]};
      end
      default: begin
        need_nxt = 2'd0;
        if (fb < 8'h80) begin
          draw1 = 1'b1;
          code1 = 16'(fb);
        end else if ((fb & 8'hE0) == 8'hC0 && !in_last_byte) begin
          lead_nxt = fb;
          need_nxt = 2'd1;
        end else if ((fb & 8'hF0) == 8'hE0 && !in_last_byte) begin
          lead_nxt = fb;
          need_nxt = 2'd2;
        end else begin
          draw1 = 1'b1;
        end
      end
    endcase
  end

  assign pos = 6'(row_r) * 6'(ROM_COLS) + 6'(col_idx_r);
  assign flat = {glyph_r[0], glyph_r[1], glyph_r[2], glyph_r[3],
                 glyph_r[4], glyph_r[5], glyph_r[6]};
  assign dot = flat[6'd34 - pos];
  assign scan_end = (pos == 6'd34);
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < 35; i++)
      if (6'(i) > pos && flat[34 - i]) more = 1'b1;
  end

  assign stat.two_chars = two_r;
  assign stat.draw1 = draw1_r;
  assign stat.dot = dot;
  assign stat.scan_end = scan_end;
  assign stat.more_dots = more;
  assign stat.more_second = |glyph2_r;

  assign cadd = {2'b0, cursor_r} + 18'(6 * 1) * 18'(sc_r);
  always_comb begin
    cursor_nxt = (cadd > 18'h0FFFF) ? 16'hFFFF : cadd[15:0];
  end

  assign sx = 18'(ox_r) + 18'(cursor_r) + 18'(xoff_r);
  assign sy = 18'(oy_r) + 18'(yoff_r);
  assign sq_x = (sx > 18'h0FFFF) ? 16'hFFFF : sx[15:0];
  assign sq_y = (sy > 18'h0FFFF) ? 16'hFFFF : sy[15:0];
  assign sq_size = sc_r;
  assign sq_color = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      second_r <= '0;
      need_r <= '0;
      cursor_r <= '0;
      two_r <= 1'b0;
      draw1_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        lead_r <= lead_nxt;
        second_r <= second_nxt;
        need_r <= need_nxt;
        two_r <= two;
        draw1_r <= draw1;
      end
      if (cmd.advance) cursor_r <= cursor_nxt;
      if (cmd.clear) begin
        lead_r <= '0;
        second_r <= '0;
        need_r <= '0;
        cursor_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ox_r <= in_origin_x;
      oy_r <= in_origin_y;
      sc_r <= in_dot_scale;
      col_r <= in_color_tag;
      glyph_r <= glyph_lookup(code1);
      glyph2_r <= glyph_lookup(code2);
      row_r <= '0;
      col_idx_r <= '0;
      xoff_r <= '0;
      yoff_r <= '0;
    end else if (cmd.second) begin
      glyph_r <= glyph2_r;
      row_r <= '0;
      col_idx_r <= '0;
      xoff_r <= '0;
      yoff_r <= '0;
    end else if (cmd.step) begin
      if (col_idx_r == 3'(ROM_COLS - 1)) begin
        col_idx_r <= '0;
        xoff_r <= '0;
        row_r <= row_r + 3'd1;
        yoff_r <= yoff_r + 17'(sc_r);
      end else begin
        col_idx_r <= col_idx_r + 3'd1;
        xoff_r <= xoff_r + 17'(sc_r);
      end
    end
  end

endmodule

### sv/utgr_ctrl.sv
// ----------------------------------------------------------------------------
// utgr_ctrl
// sequencer: accept, scan first character, scan second, output handshake
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module utgr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_last_square,
  output utgr_pkg::dp_cmd_t  cmd,
  input  utgr_pkg::dp_stat_t stat
);
  import utgr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_SCAN, S_OUT, S_NEXT} state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;
  logic   last_r, last_nxt;
  logic   ov_r, ov_nxt, ol_r, ol_nxt;
  logic   fin;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_last_square = ol_r;

  // accept, decode check, dot scan, square output; at scan end: is there another character?
  always_comb begin
    state_nxt = state_r;
    second_nxt = second_r;
    last_nxt = last_r;
    ov_nxt = ov_r;
    ol_nxt = ol_r;
    cmd = '0;
    fin = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          last_nxt = in_last_byte;
          second_nxt = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.draw1) state_nxt = S_SCAN;
        else fin = 1'b1;
      end
      S_SCAN: begin
        if (stat.dot) begin
          ov_nxt = 1'b1;
          ol_nxt = !stat.more_dots && !(stat.two_chars && !second_r && stat.more_second);
          state_nxt = S_OUT;
        end else if (stat.scan_end) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (stat.scan_end) state_nxt = S_NEXT;
          else begin
            cmd.step = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_NEXT: begin
        cmd.advance = 1'b1;
        if (stat.two_chars && !second_r) begin
          cmd.second = 1'b1;
          second_nxt = 1'b1;
          state_nxt = S_SCAN;
        end else fin = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (fin) begin
      cmd.clear = last_r;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      second_r <= 1'b0;
      last_r <= 1'b0;
      ov_r <= 1'b0;
      ol_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      second_r <= second_nxt;
      last_r <= last_nxt;
      ov_r <= ov_nxt;
      ol_r <= ol_nxt;
    end
  end

  `ASSERT_IMPLY(a_valid_in_out, out_valid, state_r == S_OUT, "out_valid outside output state")
  `ASSERT_IMPLY(a_stall_busy, in_valid && !in_stall, !out_valid, "item accepted with square pending")
  `ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_last_square), "square dropped")

endmodule

### sv/utf8_text_glyph_rasterizer.sv
// ----------------------------------------------------------------------------
// utf8_text_glyph_rasterizer
// utf-8 byte stream to 5x7 dot squares
// ----------------------------------------------------------------------------
// input channel: one string byte per transfer with origin, dot scale and color
// output channel: one square per set font dot, last_square on the final square
//   that a byte causes; a byte causing no square produces no transfer
// each byte is accepted in idle and checked in a decode state, then the glyph dot
//   scan visits every position (35 per character) in turn, with an output state per
//   square transfer and a next state at each character end; a byte that completes no
//   character returns to idle from the decode state
// a cut-short three-byte lead at end of string scans two characters
// in_stall is high whenever the controller is not idle: after acceptance until the byte's scan has ended
// out_stall holds the current square and freezes the scan
// after the byte marked last_byte the cursor and decode state return to zero
// reset (rst_n low, synchronous) clears decode state, cursor and out_valid
// ----------------------------------------------------------------------------
module utf8_text_glyph_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_last_byte,
  input  logic [15:0] in_origin_x,
  input  logic [15:0] in_origin_y,
  input  logic [7:0]  in_dot_scale,
  input  logic [7:0]  in_color_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_square_x,
  output logic [15:0] out_square_y,
  output logic [7:0]  out_square_size,
  output logic [7:0]  out_square_color,
  output logic        out_last_square
);
  import utgr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  utgr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_last_byte,
    .out_valid, .out_stall, .out_last_square, .cmd, .stat
  );

  utgr_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_text_byte, .in_last_byte,
    .in_origin_x, .in_origin_y, .in_dot_scale, .in_color_tag,
    .sq_x(out_square_x), .sq_y(out_square_y),
    .sq_size(out_square_size), .sq_color(out_square_color)
  );

endmodule

### tb/utf8_text_glyph_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// utf8_text_glyph_rasterizer_tb
// self-checking bench: directed string table, then random utf-8 strings
// every accepted byte runs through a local decoder and font model, and each
// square transfer is compared field by field with the oldest predicted square
// ----------------------------------------------------------------------------
module utf8_text_glyph_rasterizer_tb;

  typedef struct {
    logic [7:0]  text_byte;
    logic        last_byte;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  dot_scale;
    logic [7:0]  color_tag;
  } text_item_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  size;
    logic [7:0]  color;
    logic        last;
  } square_t;

  typedef struct {
    text_item_t item;
    int         n_squares;  // -1 when only the local model decides
  } table_row_t;

  localparam logic [15:0] QMARK = 16'h003F;
  localparam int MAX_SQUARES = 23;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [15:0] in_origin_x = '0;
  logic [15:0] in_origin_y = '0;
  logic [7:0]  in_dot_scale = '0;
  logic [7:0]  in_color_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_square_x;
  logic [15:0] out_square_y;
  logic [7:0]  out_square_size;
  logic [7:0]  out_square_color;
  logic        out_last_square;

  square_t     squares_due[$];
  square_t     byte_squares[$];
  logic [7:0]  lead_byte;
  logic [7:0]  second_byte;
  logic [1:0]  bytes_needed;
  logic [15:0] cursor_x;
  int          errors = 0;
  int          bytes_sent = 0;
  bit          quiet = 1'b0;

  utf8_text_glyph_rasterizer u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] canonical_char(input logic [15:0] c);
    logic [15:0] f;
    f = c;
    if ((c >= 16'h61 && c <= 16'h7A) || (c >= 16'h430 && c <= 16'h44F)) f = c - 16'd32;
    else if (c == 16'h451) f = 16'h401;
    case (f)
      16'h410: f = "A";
      16'h412: f = "B";
      16'h415, 16'h401: f = "E";
      16'h41A: f = "K";
      16'h41C: f = "M";
      16'h41D: f = "H";
      16'h41E: f = "O";
      16'h420: f = "P";
      16'h421: f = "C";
      16'h422: f = "T";
      16'h423: f = "Y";
      16'h425: f = "X";
      default: f = f;
    endcase
    return f;
  endfunction

  // rows top to bottom, five bits each, msb is the left column
  function automatic logic [34:0] font_bits(input logic [15:0] c);
    case (canonical_char(c))
      "A": return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "B": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      "C": return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      "D": return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      "E": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      "F": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      "G": return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
      "H": return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "I": return {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd31};
      "J": return {5'd7, 5'd2, 5'd2, 5'd2, 5'd18, 5'd18, 5'd12};
      "K": return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      "L": return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      "M": return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      "N": return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      "O": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "P": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      "Q": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      "R": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      "S": return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      "T": return {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      "U": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "V": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      "W": return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      "X": return {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      "Y": return {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      "Z": return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      "0": return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      "1": return {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      "2": return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      "3": return {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      "4": return {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      "5": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      "6": return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      "7": return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      "8": return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      "9": return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
      ":": return {5'd0, 5'd4, 5'd4, 5'd0, 5'd4, 5'd4, 5'd0};
      "/": return {5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16};
      "-": return {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      16'h411: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd30};
      16'h413: return {5'd31, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16};
      16'h414: return {5'd6, 5'd10, 5'd10, 5'd10, 5'd10, 5'd31, 5'd17};
      16'h416: return {5'd21, 5'd21, 5'd14, 5'd4, 5'd14, 5'd21, 5'd21};
      16'h417: return {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      16'h418: return {5'd17, 5'd19, 5'd21, 5'd21, 5'd21, 5'd25, 5'd17};
      16'h419: return {5'd10, 5'd4, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17};
      16'h41B: return {5'd7, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd17};
      16'h41F: return {5'd31, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17};
      16'h424: return {5'd4, 5'd14, 5'd21, 5'd21, 5'd14, 5'd4, 5'd4};
      16'h426: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd31, 5'd1};
      16'h427: return {5'd17, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd1};
      16'h428: return {5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd31};
      16'h429: return {5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd31, 5'd1};
      16'h42A: return {5'd24, 5'd8, 5'd8, 5'd14, 5'd9, 5'd9, 5'd14};
      16'h42B: return {5'd17, 5'd17, 5'd17, 5'd29, 5'd19, 5'd19, 5'd29};
      16'h42C: return {5'd16, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd30};
      16'h42D: return {5'd14, 5'd17, 5'd1, 5'd7, 5'd1, 5'd17, 5'd14};
      16'h42E: return {5'd17, 5'd21, 5'd21, 5'd29, 5'd21, 5'd21, 5'd17};
      16'h42F: return {5'd15, 5'd17, 5'd17, 5'd15, 5'd5, 5'd9, 5'd17};
      default: return '0;
    endcase
  endfunction

  task automatic render_char(input logic [15:0] c, input text_item_t it);
    logic [34:0] bits;
    square_t     sq;
    bits = font_bits(c);
    for (int r = 0; r < 7; r++) begin
      for (int k = 0; k < 5; k++) begin
        if (bits[34 - 5 * r - k] && byte_squares.size() < MAX_SQUARES) begin
          sq.x = sat16(32'(it.origin_x) + 32'(cursor_x) + k * 32'(it.dot_scale));
          sq.y = sat16(32'(it.origin_y) + r * 32'(it.dot_scale));
          sq.size = it.dot_scale;
          sq.color = it.color_tag;
          sq.last = 1'b0;
          byte_squares.push_back(sq);
        end
      end
    end
    cursor_x = sat16(32'(cursor_x) + 6 * 32'(it.dot_scale));
  endtask

  task automatic decode_fresh(input text_item_t it, input logic last);
    logic [7:0] b;
    b = it.text_byte;
    if (!b[7]) render_char({8'h00, b}, it);
    else if (b[7:5] == 3'b110 && !last) begin
      lead_byte = b;
      bytes_needed = 2'd1;
    end else if (b[7:4] == 4'b1110 && !last) begin
      lead_byte = b;
      bytes_needed = 2'd2;
    end else render_char(QMARK, it);
  endtask

  // advances the decoder by one byte and queues the squares it draws
  task automatic predict_squares(input text_item_t it, output int n);
    logic [15:0] c;
    byte_squares.delete();
    if (bytes_needed == 2'd2) begin
      if (it.last_byte) begin
        bytes_needed = 2'd0;
        render_char(QMARK, it);
        decode_fresh(it, 1'b1);
      end else begin
        second_byte = it.text_byte;
        bytes_needed = 2'd1;
      end
    end else if (bytes_needed == 2'd1) begin
      if (lead_byte[7:4] == 4'b1110)
        c = {lead_byte[3:0], second_byte[5:0], it.text_byte[5:0]};
      else
        c = {5'd0, lead_byte[4:0], it.text_byte[5:0]};
      bytes_needed = 2'd0;
      render_char(c, it);
    end else begin
      bytes_needed = 2'd0;
      decode_fresh(it, it.last_byte);
    end
    n = byte_squares.size();
    if (n > 0) byte_squares[n - 1].last = 1'b1;
    foreach (byte_squares[i]) squares_due.push_back(byte_squares[i]);
    if (it.last_byte) begin
      lead_byte = '0;
      second_byte = '0;
      bytes_needed = '0;
      cursor_x = '0;
    end
  endtask

  task automatic send_byte(input text_item_t it, input int n_typed);
    int n;
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_text_byte = it.text_byte;
    in_last_byte = it.last_byte;
    in_origin_x = it.origin_x;
    in_origin_y = it.origin_y;
    in_dot_scale = it.dot_scale;
    in_color_tag = it.color_tag;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_squares(it, n);
    if (n_typed >= 0 && n != n_typed) begin
      $error("square count: expected %0d, actual %0d", n_typed, n);
      errors++;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic text_item_t mk(input logic [7:0] b, input logic last,
                                    input logic [15:0] ox, input logic [15:0] oy,
                                    input logic [7:0] sc, input logic [7:0] col);
    text_item_t it;
    it.text_byte = b;
    it.last_byte = last;
    it.origin_x = ox;
    it.origin_y = oy;
    it.dot_scale = sc;
    it.color_tag = col;
    return it;
  endfunction

  always @(negedge clk) out_stall <= rst_n && !quiet && ($urandom_range(99) < 38);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (squares_due.size() == 0) begin
        $error("square transfer with nothing predicted");
        errors++;
      end else begin
        square_t e;
        e = squares_due.pop_front();
        if (out_square_x !== e.x) begin
          $error("square_x: expected %h, actual %h", e.x, out_square_x);
          errors++;
        end
        if (out_square_y !== e.y) begin
          $error("square_y: expected %h, actual %h", e.y, out_square_y);
          errors++;
        end
        if (out_square_size !== e.size) begin
          $error("square_size: expected %h, actual %h", e.size, out_square_size);
          errors++;
        end
        if (out_square_color !== e.color) begin
          $error("square_color: expected %h, actual %h", e.color, out_square_color);
          errors++;
        end
        if (out_last_square !== e.last) begin
          $error("last_square: expected %b, actual %b", e.last, out_last_square);
          errors++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("utf8_text_glyph_rasterizer verification failed");
    $finish;
  end

  initial begin
    table_row_t  dir_rows[$];
    logic [7:0]  str[$];
    logic [15:0] ox, oy, cp;
    logic [7:0]  sc, col;
    int          kind, len;
    lead_byte = '0;
    second_byte = '0;
    bytes_needed = '0;
    cursor_x = '0;
    dir_rows = '{
      '{mk("A", 1'b0, 16'h0000, 16'h0000, 8'h10, 8'h00), -1},
      '{mk("a", 1'b0, 16'h0000, 16'h0000, 8'h10, 8'hFF), -1},
      '{mk("-", 1'b1, 16'h0100, 16'h0200, 8'h00, 8'h5A), 5},
      '{mk(8'hFF, 1'b0, 16'h0000, 16'h0000, 8'h10, 8'h01), 0},
      '{mk(8'h80, 1'b0, 16'h0000, 16'h0000, 8'h10, 8'h01), 0},
      '{mk(8'h00, 1'b0, 16'h0000, 16'h0000, 8'h10, 8'h01), 0},
      '{mk(8'hD0, 1'b0, 16'h1234, 16'h4321, 8'h20, 8'h33), 0},
      '{mk(8'h90, 1'b0, 16'h1234, 16'h4321, 8'h20, 8'h33), -1},
      '{mk(8'hD0, 1'b0, 16'h1234, 16'h4321, 8'h20, 8'h33), 0},
      '{mk(8'hB6, 1'b0, 16'h1234, 16'h4321, 8'h20, 8'h33), -1},
      '{mk(8'hD1, 1'b0, 16'h1234, 16'h4321, 8'h20, 8'h33), 0},
      '{mk(8'h91, 1'b0, 16'h1234, 16'h4321, 8'h20, 8'h33), -1},
      '{mk(8'hD0, 1'b0, 16'h0000, 16'h0000, 8'hFF, 8'hC3), 0},
      '{mk(8'hA8, 1'b0, 16'h0000, 16'h0000, 8'hFF, 8'hC3), 23},
      '{mk(8'hE2, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h7E), 0},
      '{mk(8'h80, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h7E), 0},
      '{mk(8'h94, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h7E), 0},
      '{mk("W", 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h7E), -1},
      '{mk(8'h7F, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h7E), 0},
      '{mk(8'hD0, 1'b1, 16'h0040, 16'h0040, 8'h10, 8'h11), 0},
      '{mk(8'hE0, 1'b0, 16'h0040, 16'h0040, 8'h10, 8'h22), 0},
      '{mk("Z", 1'b1, 16'h0040, 16'h0040, 8'h10, 8'h22), -1},
      '{mk(8'hEF, 1'b0, 16'h0040, 16'h0040, 8'h10, 8'h44), 0},
      '{mk(8'hC3, 1'b1, 16'h0040, 16'h0040, 8'h10, 8'h44), 0}
    };
    repeat (10) @(posedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) send_byte(dir_rows[i].item, dir_rows[i].n_squares);
    while (bytes_sent < 525) begin
      quiet = (bytes_sent >= 250 && bytes_sent < 330);
      ox = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(16'h2000));
      oy = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(16'h2000));
      sc = $urandom_range(4) == 0 ? 8'($urandom) : 8'($urandom_range(8'h08, 8'h30));
      col = 8'($urandom);
      str.delete();
      len = $urandom_range(1, 8);
      for (int c = 0; c < len; c++) begin
        kind = $urandom_range(9);
        if (kind < 3) begin
          cp = 16'($urandom_range(2) == 0 ? $urandom_range(16'h30, 16'h3A)
                                          : $urandom_range(16'h41, 16'h5A));
          if ($urandom_range(1)) cp[5] = 1'b1;
          if (cp < 16'h40) cp[5] = 1'b1;
          str.push_back(cp[7:0]);
        end else if (kind < 6) begin
          cp = 16'($urandom_range(16'h400, 16'h45F));
          str.push_back({3'b110, cp[10:6]});
          str.push_back({2'b10, cp[5:0]});
        end else if (kind == 6) begin
          str.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          str.push_back(8'($urandom));
        end else if (kind == 7) begin
          str.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          str.push_back(8'($urandom));
          str.push_back(8'($urandom));
        end else if (kind == 8) begin
          str.push_back(8'($urandom_range(127)));
        end else begin
          str.push_back(8'($urandom));
        end
      end
      if (str.size() > 1 && $urandom_range(6) == 0) void'(str.pop_back());
      foreach (str[i]) begin
        if ($urandom_range(9) == 0) begin
          sc = 8'($urandom);
          col = 8'($urandom);
        end
        send_byte(mk(str[i], i == str.size() - 1, ox, oy, sc, col), -1);
      end
    end
    quiet = 1'b0;
    in_valid = 1'b0;
    wait (squares_due.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && squares_due.size() == 0)
      $display("utf8_text_glyph_rasterizer verification clean");
    else
      $display("utf8_text_glyph_rasterizer verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/utgr_pkg.sv
sv/utgr_datapath.sv
sv/utgr_ctrl.sv
sv/utf8_text_glyph_rasterizer.sv
tb/utf8_text_glyph_rasterizer_tb.sv
